### src/lcjdz_pkg.sv
// Shared types, constants and the axis shaping function of the load-cell joystick unit.
// No dependencies; imported by the top level.
package lcjdz_pkg;

    // Field widths fixed by the sample and axis formats.
    localparam int SAMPLE_W   = 16;
    localparam int AVG_W      = 17;
    localparam int DIFF_W     = 18;
    localparam int AXIS_W     = 8;
    localparam int DZ_W       = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int CELL_COUNT = 4;
    localparam int AXIS_LIMIT = 127;

    // Register map, one 32-bit word per register.
    typedef enum logic [2:0] {
        REG_OFFSET_NORTH = 3'd0,
        REG_OFFSET_SOUTH = 3'd1,
        REG_OFFSET_EAST  = 3'd2,
        REG_OFFSET_WEST  = 3'd3,
        REG_DEAD_ZONE    = 3'd4
    } reg_index_t;

    // Cells arrive in this fixed order.
    typedef enum logic [1:0] {
        CELL_NORTH = 2'd0,
        CELL_SOUTH = 2'd1,
        CELL_EAST  = 2'd2,
        CELL_WEST  = 2'd3
    } cell_t;

    // Magnitude and direction of one axis before the dead zone is applied.
    typedef struct packed {
        logic [DIFF_W-1:0] mag;
        logic              neg;
    } axis_diff_t;

    // Removes the dead zone, clamps to the axis limit and applies the direction.
    function automatic logic signed [AXIS_W-1:0] axis_value(
        input axis_diff_t       d,
        input logic [DZ_W-1:0]  dz
    );
        logic [DIFF_W-1:0] excess;
        logic [AXIS_W-1:0] mag8;
        excess = d.mag - {{(DIFF_W-DZ_W){1'b0}}, dz};
        if (d.mag <= {{(DIFF_W-DZ_W){1'b0}}, dz}) begin
            mag8 = '0;
        end else if (excess > DIFF_W'(AXIS_LIMIT)) begin
            mag8 = AXIS_W'(AXIS_LIMIT);
        end else begin
            mag8 = excess[AXIS_W-1:0];
        end
        return d.neg ? AXIS_W'(-mag8) : mag8;
    endfunction

endpackage

### src/load_cell_joystick_axis_deadzone_unit.sv
// Load-cell joystick axis unit: per-cell averaging, dead zone and clamp.
// Depends on lcjdz_pkg for widths, register codes and the axis function.
//
// Usage:
//   The slave stream carries one signed 16-bit ADC sample per beat. Samples
//   arrive as SAMPLES_PER_CHANNEL beats of the north cell, then south, east
//   and west. After the last west beat the unit emits one master beat with
//   the X and Y axes (-127..127). All other beats produce no output.
//   The APB port holds the four cell offsets and the dead zone; the user
//   must write it only while the unit is idle, which the unit does not enforce.
// Throughput: one sample per cycle unless stalled. Every stage is a single
//   short step (add, abs, one multiply by the reciprocal of the sample count,
//   axis diff, dead-zone clamp), so the pipeline never iterates.
// Path: the final west sample passes the accumulate, abs, multiply, average
//   store, diff and clamp registers before the result beat is valid.
// Reset: synchronous, active low. Offsets, dead zone, accumulator and
//   sample counters clear; averages are rewritten every round.
// Stall: a result waits in the output register while samples keep flowing.
//   Only when a second result reaches the output stage before the first is
//   taken does the whole pipeline hold and s_tready drop.
module load_cell_joystick_axis_deadzone_unit
    import lcjdz_pkg::*;
#(
    parameter int SAMPLES_PER_CHANNEL = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Sample stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] sample
    // Axis stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [7:0] axis_x, [15:8] axis_y
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Widths derived from the sample count.
    localparam int LOG_N     = $clog2(SAMPLES_PER_CHANNEL);
    localparam int WIN_W     = (LOG_N > 0) ? LOG_N : 1;
    localparam int MAG_W     = AVG_W + LOG_N;
    localparam int SUM_W     = MAG_W + 1;
    localparam int DIV_SHIFT = MAG_W + LOG_N;
    localparam int REC_W     = MAG_W + 2;
    localparam int PROD_W    = MAG_W + REC_W;
    localparam longint RECIP =
        ((longint'(1) << DIV_SHIFT) + SAMPLES_PER_CHANNEL - 1) / SAMPLES_PER_CHANNEL;

    // Configuration registers.
    logic signed [SAMPLE_W-1:0] off_n_reg, off_s_reg, off_e_reg, off_w_reg;
    logic [DZ_W-1:0]            dz_reg;

    // Accumulator and position within the round.
    logic signed [SUM_W-1:0] sum_reg;
    logic [WIN_W-1:0]        win_reg;
    cell_t                   cell_reg;

    // Pipeline: divide input, magnitude, product, averages, diffs, output.
    logic                    div_valid_reg;
    cell_t                   div_cell_reg;
    logic signed [SUM_W-1:0] div_sum_reg;
    logic                    mag_valid_reg;
    cell_t                   mag_cell_reg;
    logic                    mag_neg_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic                    prod_valid_reg;
    cell_t                   prod_cell_reg;
    logic                    prod_neg_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic signed [AVG_W-1:0] avg_reg [CELL_COUNT];
    logic                    done_reg;
    logic                    dif_valid_reg;
    axis_diff_t              dif_x_reg, dif_y_reg;
    logic                    m_tvalid_reg;
    logic [15:0]             m_tdata_reg;

    logic                    stall;
    logic                    accept;
    logic                    last_in_cell;
    logic signed [SAMPLE_W-1:0] cur_off;
    logic signed [AVG_W-1:0]    term;
    logic signed [SUM_W-1:0]    sum_next;
    logic [AVG_W-1:0]           quot;
    logic signed [AVG_W-1:0]    avg_next;
    logic signed [DIFF_W-1:0]   dy, dx;
    logic                       cfg_write;
    reg_index_t                 cfg_idx;

    // Handshake: hold everything only when a new result meets a full output.
    assign stall    = m_tvalid_reg && !m_tready && dif_valid_reg;
    assign s_tready = !stall;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Configuration decode and read-back.
    assign pready    = 1'b1;
    assign cfg_idx   = reg_index_t'(paddr[CFG_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_OFFSET_NORTH: prdata = CFG_DATA_W'(off_n_reg);
            REG_OFFSET_SOUTH: prdata = CFG_DATA_W'(off_s_reg);
            REG_OFFSET_EAST:  prdata = CFG_DATA_W'(off_e_reg);
            REG_OFFSET_WEST:  prdata = CFG_DATA_W'(off_w_reg);
            REG_DEAD_ZONE:    prdata = {{(CFG_DATA_W-DZ_W){1'b0}}, dz_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_n_reg <= '0;
            off_s_reg <= '0;
            off_e_reg <= '0;
            off_w_reg <= '0;
            dz_reg    <= '0;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_OFFSET_NORTH: off_n_reg <= pwdata[SAMPLE_W-1:0];
                REG_OFFSET_SOUTH: off_s_reg <= pwdata[SAMPLE_W-1:0];
                REG_OFFSET_EAST:  off_e_reg <= pwdata[SAMPLE_W-1:0];
                REG_OFFSET_WEST:  off_w_reg <= pwdata[SAMPLE_W-1:0];
                REG_DEAD_ZONE:    dz_reg    <= pwdata[DZ_W-1:0];
                default:          ;
            endcase
        end
    end

    // Offset of the cell being sampled, subtracted from each beat.
    always_comb begin
        unique case (cell_reg)
            CELL_NORTH: cur_off = off_n_reg;
            CELL_SOUTH: cur_off = off_s_reg;
            CELL_EAST:  cur_off = off_e_reg;
            CELL_WEST:  cur_off = off_w_reg;
            default:    cur_off = off_n_reg;
        endcase
    end

    assign term = {s_tdata[SAMPLE_W-1], s_tdata} - {cur_off[SAMPLE_W-1], cur_off};
    assign sum_next = ((win_reg == '0) ? '0 : sum_reg)
                    + {{(SUM_W-AVG_W){term[AVG_W-1]}}, term};
    assign last_in_cell = (win_reg == WIN_W'(SAMPLES_PER_CHANNEL - 1));

    // Accumulator and round position, advanced per accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            win_reg  <= '0;
            cell_reg <= CELL_NORTH;
        end else if (accept) begin
            sum_reg <= last_in_cell ? '0 : sum_next;
            if (last_in_cell) begin
                win_reg  <= '0;
                cell_reg <= cell_t'(cell_reg + 2'd1);
            end else begin
                win_reg <= win_reg + WIN_W'(1);
            end
        end
    end

    // Division by the sample count: reciprocal multiply on the magnitude.
    assign quot     = prod_reg[DIV_SHIFT +: AVG_W];
    assign avg_next = prod_neg_reg ? AVG_W'(-quot) : quot;

    // Axis differences from the four stored averages.
    assign dy = {avg_reg[CELL_SOUTH][AVG_W-1], avg_reg[CELL_SOUTH]}
              - {avg_reg[CELL_NORTH][AVG_W-1], avg_reg[CELL_NORTH]};
    assign dx = {avg_reg[CELL_WEST][AVG_W-1], avg_reg[CELL_WEST]}
              - {avg_reg[CELL_EAST][AVG_W-1], avg_reg[CELL_EAST]};

    // Pipeline valid bits and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_valid_reg  <= 1'b0;
            mag_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
            dif_valid_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (!stall) begin
                div_valid_reg  <= accept && last_in_cell;
                mag_valid_reg  <= div_valid_reg;
                prod_valid_reg <= mag_valid_reg;
                done_reg       <= prod_valid_reg && (prod_cell_reg == CELL_WEST);
                dif_valid_reg  <= done_reg;
            end
            if (dif_valid_reg && !stall) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge aclk) begin
        if (!stall) begin
            div_cell_reg  <= cell_reg;
            div_sum_reg   <= sum_next;
            mag_cell_reg  <= div_cell_reg;
            mag_neg_reg   <= div_sum_reg[SUM_W-1];
            mag_reg       <= div_sum_reg[SUM_W-1] ? MAG_W'(-div_sum_reg)
                                                  : MAG_W'(div_sum_reg);
            prod_cell_reg <= mag_cell_reg;
            prod_neg_reg  <= mag_neg_reg;
            prod_reg      <= PROD_W'(mag_reg) * PROD_W'(REC_W'(RECIP));
            if (prod_valid_reg) begin
                avg_reg[prod_cell_reg] <= avg_next;
            end
            dif_y_reg.neg <= dy[DIFF_W-1];
            dif_y_reg.mag <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
            dif_x_reg.neg <= dx[DIFF_W-1];
            dif_x_reg.mag <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        end
        if (dif_valid_reg && !stall) begin
            m_tdata_reg <= {axis_value(dif_y_reg, dz_reg), axis_value(dif_x_reg, dz_reg)};
        end
    end

    // The axes never reach the most negative code.
    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] != 8'h80) && (m_tdata[15:8] != 8'h80))
        else $error("axis value outside -127..127");

    // The final west beat wraps the round back to the north cell.
    a_round_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && last_in_cell && (cell_reg == CELL_WEST)
        |=> (cell_reg == CELL_NORTH) && (win_reg == '0))
        else $error("round position did not wrap after the west cell");

    // A round spans all four cells, so two results never overlap.
    a_result_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({done_reg, dif_valid_reg}))
        else $error("two round results in flight at once");

    // A result reaching a held output must freeze the sample side.
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && dif_valid_reg |=> $stable(sum_reg) && $stable(win_reg))
        else $error("accumulator moved while the pipeline was held");

endmodule
